@@ design/fcu_pkg.sv @@
package fcu_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int COR_ITERS    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int SQRT_ITERS   = 22;
  localparam int DIV_ITERS    = 15;
  localparam int CNT_W        = $clog2(((COR_ITERS > SQRT_ITERS) ? COR_ITERS : SQRT_ITERS) + 1);

  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [15:0] YAW_START   = -16'sd17280;
  localparam logic signed [14:0] PITCH_START = -15'sd4513;
  localparam logic signed [32:0] CORDIC_X0   = 33'sd652032874;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_ORIENT = 2'd1,
    OP_MOVE   = 2'd2,
    OP_NOP    = 2'd3
  } fcu_op_t;

  typedef enum logic [2:0] {
    DIR_FWD   = 3'd0,
    DIR_BACK  = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_UP    = 3'd4,
    DIR_DOWN  = 3'd5
  } fcu_dir_t;

  typedef enum logic [2:0] {
    REG_UP_X    = 3'd0,
    REG_UP_Y    = 3'd1,
    REG_UP_Z    = 3'd2,
    REG_START_X = 3'd3,
    REG_START_Y = 3'd4,
    REG_START_Z = 3'd5
  } fcu_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COR_P,
    ST_COR_Y,
    ST_FWD,
    ST_CROSS,
    ST_NORM,
    ST_SQ,
    ST_SQRT,
    ST_DIV,
    ST_SIDE,
    ST_OUT
  } fcu_state_t;

  typedef struct packed {
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
  } fcu_cfg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [10:0] mouse_dx;
    logic signed [10:0] mouse_dy;
    logic [2:0]         move_dir;
  } fcu_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [15:0] side_x;
    logic signed [15:0] side_y;
    logic signed [15:0] side_z;
  } fcu_res_t;

  typedef struct packed {
    logic             load;
    logic             apply;
    logic             cor_init;
    logic             cor_sel_yaw;
    logic             cor_step;
    logic             save_p;
    logic             save_y;
    logic             fwd_mul0;
    logic             fwd_mul1;
    logic             fwd_set;
    logic             cross_mul;
    logic             norm_step;
    logic             side_zero;
    logic             sq_mul;
    logic             sqrt_step;
    logic             div_init;
    logic             div_step;
    logic             side_set;
    logic             out_load;
    logic [CNT_W-1:0] idx;
  } fcu_cmd_t;

  typedef struct packed {
    fcu_op_t op;
    logic    norm_done;
    logic    cross_zero;
    logic    out_busy;
  } fcu_stat_t;

  function automatic logic [21:0] atan_q16(input logic [CNT_W-1:0] i);
    logic [21:0] v;
    case (i)
      0:  v = 22'd2949120;
      1:  v = 22'd1740967;
      2:  v = 22'd919879;
      3:  v = 22'd466945;
      4:  v = 22'd234379;
      5:  v = 22'd117304;
      6:  v = 22'd58666;
      7:  v = 22'd29335;
      8:  v = 22'd14668;
      9:  v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      20: v = 22'd4;
      21: v = 22'd2;
      22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -34'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ design/fcu_if.sv @@
interface fcu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [10:0] mouse_dx;
  logic signed [10:0] mouse_dy;
  logic [2:0]         move_dir;

  modport source (output valid, cmd, mouse_dx, mouse_dy, move_dir, input ready);
  modport sink (input valid, cmd, mouse_dx, mouse_dy, move_dir, output ready);
endinterface

interface fcu_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] target_x;
  logic signed [31:0] target_y;
  logic signed [31:0] target_z;
  logic signed [15:0] fwd_x;
  logic signed [15:0] fwd_y;
  logic signed [15:0] fwd_z;
  logic signed [15:0] side_x;
  logic signed [15:0] side_y;
  logic signed [15:0] side_z;

  modport source (output valid, pos_x, pos_y, pos_z, target_x, target_y, target_z,
                  fwd_x, fwd_y, fwd_z, side_x, side_y, side_z, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, target_x, target_y, target_z,
                fwd_x, fwd_y, fwd_z, side_x, side_y, side_z, output ready);
endinterface

@@ design/fcu_ctrl.sv @@
module fcu_ctrl import fcu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  fcu_stat_t stat,
  output fcu_cmd_t  cmd
);

  fcu_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r + 1'b1;
    cmd       = '0;
    cmd.idx   = cnt_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cnt_nxt  = '0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.apply = 1'b1;
        cnt_nxt   = '0;
        if (stat.op == OP_INIT || stat.op == OP_ORIENT) begin
          state_nxt = ST_COR_P;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_COR_P, ST_COR_Y: begin
        cmd.cor_sel_yaw = (state_r == ST_COR_Y);
        if (cnt_r == '0) begin
          cmd.cor_init = 1'b1;
          cmd.save_p   = (state_r == ST_COR_Y);
        end else begin
          cmd.cor_step = 1'b1;
          cmd.idx      = cnt_r - 1'b1;
        end
        if (cnt_r == CNT_W'(COR_ITERS)) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == ST_COR_P) ? ST_COR_Y : ST_FWD;
        end
      end
      ST_FWD: begin
        case (cnt_r)
          0: cmd.save_y   = 1'b1;
          1: cmd.fwd_mul0 = 1'b1;
          2: cmd.fwd_mul1 = 1'b1;
          default: begin
            cmd.fwd_set = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = ST_CROSS;
          end
        endcase
      end
      ST_CROSS: begin
        cmd.cross_mul = 1'b1;
        if (cnt_r == CNT_W'(5)) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        cnt_nxt = '0;
        if (!stat.norm_done) begin
          cmd.norm_step = 1'b1;
        end else if (stat.cross_zero) begin
          cmd.side_zero = 1'b1;
          state_nxt     = ST_OUT;
        end else begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq_mul = 1'b1;
        if (cnt_r == CNT_W'(2)) begin
          cnt_nxt   = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == CNT_W'(SQRT_ITERS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == '0) begin
          cmd.div_init = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
        if (cnt_r == CNT_W'(DIV_ITERS)) begin
          state_nxt = ST_SIDE;
        end
      end
      ST_SIDE: begin
        cmd.side_set = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ design/fcu_dp.sv @@
module fcu_dp import fcu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  fcu_cmd_t  cmd,
  output fcu_stat_t stat,
  input  fcu_cfg_t  cfg,
  input  fcu_item_t item,
  output fcu_res_t  res,
  output logic      out_valid,
  input  logic      out_ready
);

  fcu_op_t            op_r;
  logic signed [10:0] dx_r, dy_r;
  logic [2:0]         dir_r;

  logic signed [15:0] yaw_r;
  logic signed [14:0] pitch_r;
  logic signed [15:0] fwd_r [3];
  logic signed [15:0] side_r [3];
  logic signed [31:0] pos_r [3];

  logic signed [32:0] x_r, y_r;
  logic signed [24:0] z_r;
  logic               flip_r;
  logic signed [15:0] sp_r, cp_r, st_r, ct_r, m0_r, m1_r;
  logic signed [32:0] tmp_r;
  logic signed [32:0] c_r [3];
  logic [41:0]        acc_r;
  logic [43:0]        sv_r, sr_r;
  logic [20:0]        rem_r [3];
  logic [14:0]        ql_r [3];
  fcu_res_t           out_r;
  logic               out_valid_r;

  // angle update
  logic signed [16:0] dx64, dy64;
  logic signed [18:0] yaw_t, yaw_w;
  logic signed [17:0] pitch_t;
  logic signed [15:0] yaw_new;
  logic signed [14:0] pitch_new;

  assign dx64  = {dx_r, 6'b0};
  assign dy64  = {dy_r, 6'b0};
  assign yaw_t = 19'(yaw_r) - 19'(dx64) + 19'sd23040;
  assign pitch_t = 18'(pitch_r) - 18'(dy64);

  always_comb begin
    if (yaw_t >= 19'sd92160) begin
      yaw_w = yaw_t - 19'sd92160;
    end else if (yaw_t >= 19'sd46080) begin
      yaw_w = yaw_t - 19'sd46080;
    end else if (yaw_t < -19'sd46080) begin
      yaw_w = yaw_t + 19'sd92160;
    end else if (yaw_t < 19'sd0) begin
      yaw_w = yaw_t + 19'sd46080;
    end else begin
      yaw_w = yaw_t;
    end
    yaw_new = 16'(yaw_w - 19'sd23040);
    if (pitch_t > 18'sd11392) begin
      pitch_new = 15'sd11392;
    end else if (pitch_t < -18'sd11392) begin
      pitch_new = -15'sd11392;
    end else begin
      pitch_new = 15'(pitch_t);
    end
  end

  // move step
  logic signed [15:0] mv [3];
  logic               mv_neg, mv_en;
  logic signed [31:0] pos_mv [3];

  always_comb begin
    mv[0]  = fwd_r[0];
    mv[1]  = fwd_r[1];
    mv[2]  = fwd_r[2];
    mv_neg = 1'b0;
    mv_en  = 1'b1;
    case (dir_r)
      DIR_FWD: ;
      DIR_BACK: mv_neg = 1'b1;
      DIR_LEFT: begin
        mv[0] = side_r[0];
        mv[1] = side_r[1];
        mv[2] = side_r[2];
      end
      DIR_RIGHT: begin
        mv[0]  = side_r[0];
        mv[1]  = side_r[1];
        mv[2]  = side_r[2];
        mv_neg = 1'b1;
      end
      DIR_UP: begin
        mv[0] = cfg.up_x;
        mv[1] = cfg.up_y;
        mv[2] = cfg.up_z;
      end
      DIR_DOWN: begin
        mv[0]  = cfg.up_x;
        mv[1]  = cfg.up_y;
        mv[2]  = cfg.up_z;
        mv_neg = 1'b1;
      end
      default: mv_en = 1'b0;
    endcase
    for (int k = 0; k < 3; k++) begin
      if (mv_neg) begin
        pos_mv[k] = sat32(34'(pos_r[k]) - 34'(mv[k]) * 34'sd2);
      end else begin
        pos_mv[k] = sat32(34'(pos_r[k]) + 34'(mv[k]) * 34'sd2);
      end
    end
  end

  // CORDIC
  logic signed [15:0] ang;
  logic signed [16:0] ang_f;
  logic               ang_flip;
  logic signed [32:0] cdx, cdy;
  logic signed [24:0] cat;
  logic signed [32:0] xs, ys;
  logic signed [16:0] xq, yq;
  logic signed [15:0] cor_c, cor_s;

  function automatic logic signed [15:0] clamp14(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd16384) begin
      r = ONE_Q14;
    end else if (v < -17'sd16384) begin
      r = -ONE_Q14;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  always_comb begin
    ang = cmd.cor_sel_yaw ? yaw_r : 16'(pitch_r);
    ang_flip = 1'b1;
    if (ang > 16'sd11520) begin
      ang_f = 17'(ang) - 17'sd23040;
    end else if (ang < -16'sd11520) begin
      ang_f = 17'(ang) + 17'sd23040;
    end else begin
      ang_f    = 17'(ang);
      ang_flip = 1'b0;
    end
    cdx   = y_r >>> cmd.idx;
    cdy   = x_r >>> cmd.idx;
    cat   = 25'(atan_q16(cmd.idx));
    xs    = x_r + 33'sd32768;
    ys    = y_r + 33'sd32768;
    xq    = xs[32:16];
    yq    = ys[32:16];
    cor_c = flip_r ? -clamp14(xq) : clamp14(xq);
    cor_s = flip_r ? -clamp14(yq) : clamp14(yq);
  end

  // shared multiplier
  logic signed [21:0] mul_a, mul_b;
  logic signed [43:0] prod, prod_rnd;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd.fwd_mul0) begin
      mul_a = 22'(cp_r);
      mul_b = 22'(ct_r);
    end else if (cmd.fwd_mul1) begin
      mul_a = 22'(cp_r);
      mul_b = 22'(st_r);
    end else if (cmd.cross_mul) begin
      case (cmd.idx)
        0: begin mul_a = 22'(cfg.up_y); mul_b = 22'(fwd_r[2]); end
        1: begin mul_a = 22'(cfg.up_z); mul_b = 22'(fwd_r[1]); end
        2: begin mul_a = 22'(cfg.up_z); mul_b = 22'(fwd_r[0]); end
        3: begin mul_a = 22'(cfg.up_x); mul_b = 22'(fwd_r[2]); end
        4: begin mul_a = 22'(cfg.up_x); mul_b = 22'(fwd_r[1]); end
        default: begin mul_a = 22'(cfg.up_y); mul_b = 22'(fwd_r[0]); end
      endcase
    end else if (cmd.sq_mul) begin
      mul_a = c_r[cmd.idx[1:0]][21:0];
      mul_b = c_r[cmd.idx[1:0]][21:0];
    end
    prod     = mul_a * mul_b;
    prod_rnd = prod + 44'sd8192;
  end

  // normalization of the cross product
  logic [32:0] cabs [3];
  logic [32:0] mx;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cabs[k] = c_r[k][32] ? 33'(-c_r[k]) : 33'(c_r[k]);
    end
    mx = cabs[0];
    if (cabs[1] > mx) mx = cabs[1];
    if (cabs[2] > mx) mx = cabs[2];
  end

  // square root step
  logic [43:0] v_in, r_in, sbit, rb;
  logic [5:0]  sh;

  always_comb begin
    v_in = (cmd.idx == '0) ? 44'(acc_r) : sv_r;
    r_in = (cmd.idx == '0) ? '0 : sr_r;
    sh   = 6'd42 - {cmd.idx, 1'b0};
    sbit = 44'd1 << sh;
    rb   = r_in + sbit;
  end

  logic [20:0] len;
  assign len = sr_r[20:0];

  logic [34:0] num [3];
  logic [21:0] dt  [3];
  logic [14:0] qc  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = {cabs[k][19:0], 14'b0} + 35'(len >> 1);
      dt[k]  = {rem_r[k], ql_r[k][14]};
      qc[k]  = (ql_r[k] > 15'd16384) ? 15'd16384 : ql_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      yaw_r       <= YAW_START;
      pitch_r     <= PITCH_START;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        fwd_r[k]  <= '0;
        side_r[k] <= '0;
        pos_r[k]  <= '0;
      end
    end else begin
      if (cmd.apply) begin
        case (op_r)
          OP_INIT: begin
            yaw_r    <= YAW_START;
            pitch_r  <= PITCH_START;
            pos_r[0] <= cfg.start_x;
            pos_r[1] <= cfg.start_y;
            pos_r[2] <= cfg.start_z;
          end
          OP_ORIENT: begin
            yaw_r   <= yaw_new;
            pitch_r <= pitch_new;
          end
          OP_MOVE: begin
            if (mv_en) begin
              for (int k = 0; k < 3; k++) pos_r[k] <= pos_mv[k];
            end
          end
          default: ;
        endcase
      end
      if (cmd.fwd_set) begin
        if (cfg.up_x == ONE_Q14) begin
          fwd_r[0] <= sp_r;
          fwd_r[1] <= m0_r;
          fwd_r[2] <= m1_r;
        end else if (cfg.up_y == ONE_Q14) begin
          fwd_r[0] <= m1_r;
          fwd_r[1] <= sp_r;
          fwd_r[2] <= m0_r;
        end else begin
          fwd_r[0] <= m0_r;
          fwd_r[1] <= m1_r;
          fwd_r[2] <= sp_r;
        end
      end
      if (cmd.side_zero) begin
        for (int k = 0; k < 3; k++) side_r[k] <= '0;
      end
      if (cmd.side_set) begin
        for (int k = 0; k < 3; k++) begin
          side_r[k] <= c_r[k][32] ? -16'(qc[k]) : 16'(qc[k]);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= fcu_op_t'(item.cmd);
      dx_r  <= item.mouse_dx;
      dy_r  <= item.mouse_dy;
      dir_r <= item.move_dir;
    end
    if (cmd.cor_init) begin
      x_r    <= CORDIC_X0;
      y_r    <= '0;
      z_r    <= 25'(ang_f) <<< 9;
      flip_r <= ang_flip;
    end else if (cmd.cor_step) begin
      if (z_r >= 25'sd0) begin
        x_r <= x_r - cdx;
        y_r <= y_r + cdy;
        z_r <= z_r - cat;
      end else begin
        x_r <= x_r + cdx;
        y_r <= y_r - cdy;
        z_r <= z_r + cat;
      end
    end
    if (cmd.save_p) begin
      sp_r <= cor_s;
      cp_r <= cor_c;
    end
    if (cmd.save_y) begin
      st_r <= cor_s;
      ct_r <= cor_c;
    end
    if (cmd.fwd_mul0) m0_r <= prod_rnd[29:14];
    if (cmd.fwd_mul1) m1_r <= prod_rnd[29:14];
    if (cmd.cross_mul) begin
      if (!cmd.idx[0]) begin
        tmp_r <= 33'(prod);
      end else begin
        c_r[cmd.idx[2:1]] <= tmp_r - 33'(prod);
      end
    end
    if (cmd.norm_step) begin
      for (int k = 0; k < 3; k++) begin
        if (mx >= 33'd1048576) begin
          c_r[k] <= c_r[k] >>> 1;
        end else begin
          c_r[k] <= c_r[k] <<< 1;
        end
      end
    end
    if (cmd.sq_mul) begin
      if (cmd.idx == '0) begin
        acc_r <= 42'(prod);
      end else begin
        acc_r <= acc_r + 42'(prod);
      end
    end
    if (cmd.sqrt_step) begin
      if (v_in >= rb) begin
        sv_r <= v_in - rb;
        sr_r <= (r_in >> 1) + sbit;
      end else begin
        sv_r <= v_in;
        sr_r <= r_in >> 1;
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (cmd.div_init) begin
        rem_r[k] <= 21'(num[k][34:15]);
        ql_r[k]  <= num[k][14:0];
      end else if (cmd.div_step) begin
        if (dt[k] >= {1'b0, len}) begin
          rem_r[k] <= 21'(dt[k] - {1'b0, len});
          ql_r[k]  <= {ql_r[k][13:0], 1'b1};
        end else begin
          rem_r[k] <= dt[k][20:0];
          ql_r[k]  <= {ql_r[k][13:0], 1'b0};
        end
      end
    end
    if (cmd.out_load) begin
      out_r.pos_x    <= pos_r[0];
      out_r.pos_y    <= pos_r[1];
      out_r.pos_z    <= pos_r[2];
      out_r.target_x <= sat32(34'(pos_r[0]) + 34'(fwd_r[0]) * 34'sd4);
      out_r.target_y <= sat32(34'(pos_r[1]) + 34'(fwd_r[1]) * 34'sd4);
      out_r.target_z <= sat32(34'(pos_r[2]) + 34'(fwd_r[2]) * 34'sd4);
      out_r.fwd_x    <= fwd_r[0];
      out_r.fwd_y    <= fwd_r[1];
      out_r.fwd_z    <= fwd_r[2];
      out_r.side_x   <= side_r[0];
      out_r.side_y   <= side_r[1];
      out_r.side_z   <= side_r[2];
    end
  end

  assign stat.op         = op_r;
  assign stat.norm_done  = (mx < 33'd1048576) && ((mx >= 33'd524288) || (mx == '0));
  assign stat.cross_zero = (mx == '0);
  assign stat.out_busy   = out_valid_r && !out_ready;
  assign res             = out_r;
  assign out_valid       = out_valid_r;

endmodule

@@ design/free_fly_camera_update.sv @@
// Free-fly camera orientation and motion unit.
// in_ch carries one item per command: init (load start position, reset the
// angles, orient), orient (turn by half the negated mouse deltas) or move
// (step half a unit along forward, side or the vertical axis). Every accepted
// item yields exactly one item on out_ch with position, target, forward and
// side vectors. The vertical axis and start position are written over the
// APB port; writes complete in the access cycle and pready is always high.
// One item is processed at a time; in_ch.ready is high only while idle.
// Move and no-op items go straight from the load state to the output
// register. Init and orient run a shared CORDIC unit twice, the forward
// and cross products through one multiplier, a shift normalization, a
// 22-step square root and a 15-step divider for the side vector; when the
// cross product is zero, the square root and divider are skipped and the
// side vector is cleared.
// A finished item waits in the output register while the next one is taken;
// a stalled receiver holds the block before its next output register load.
// Reset returns the angles to -135 and -35.26 degrees and clears vectors,
// position and the registers to their defaults.
module free_fly_camera_update import fcu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  fcu_in_if.sink      in_ch,
  fcu_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fcu_cfg_t  cfg_r;
  fcu_cmd_t  cmd;
  fcu_stat_t stat;
  fcu_item_t item;
  fcu_res_t  res;
  logic      wr_en;
  fcu_reg_t  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = fcu_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.up_x    <= '0;
      cfg_r.up_y    <= ONE_Q14;
      cfg_r.up_z    <= '0;
      cfg_r.start_x <= '0;
      cfg_r.start_y <= '0;
      cfg_r.start_z <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_UP_X:    cfg_r.up_x    <= pwdata[15:0];
        REG_UP_Y:    cfg_r.up_y    <= pwdata[15:0];
        REG_UP_Z:    cfg_r.up_z    <= pwdata[15:0];
        REG_START_X: cfg_r.start_x <= pwdata;
        REG_START_Y: cfg_r.start_y <= pwdata;
        REG_START_Z: cfg_r.start_z <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_UP_X:    prdata = 32'(cfg_r.up_x);
      REG_UP_Y:    prdata = 32'(cfg_r.up_y);
      REG_UP_Z:    prdata = 32'(cfg_r.up_z);
      REG_START_X: prdata = cfg_r.start_x;
      REG_START_Y: prdata = cfg_r.start_y;
      REG_START_Z: prdata = cfg_r.start_z;
      default:     prdata = '0;
    endcase
  end

  assign item.cmd      = in_ch.cmd;
  assign item.mouse_dx = in_ch.mouse_dx;
  assign item.mouse_dy = in_ch.mouse_dy;
  assign item.move_dir = in_ch.move_dir;

  fcu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fcu_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg       (cfg_r),
    .item      (item),
    .res       (res),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

  assign out_ch.pos_x    = res.pos_x;
  assign out_ch.pos_y    = res.pos_y;
  assign out_ch.pos_z    = res.pos_z;
  assign out_ch.target_x = res.target_x;
  assign out_ch.target_y = res.target_y;
  assign out_ch.target_z = res.target_z;
  assign out_ch.fwd_x    = res.fwd_x;
  assign out_ch.fwd_y    = res.fwd_y;
  assign out_ch.fwd_z    = res.fwd_z;
  assign out_ch.side_x   = res.side_x;
  assign out_ch.side_y   = res.side_y;
  assign out_ch.side_z   = res.side_z;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item taken while previous item in flight");

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result raised without an item in flight");

  a_fwd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.fwd_x <= 16'sd16384 && out_ch.fwd_x >= -16'sd16384 &&
                      out_ch.side_x <= 16'sd16384 && out_ch.side_x >= -16'sd16384))
    else $error("unit vector component out of range");

endmodule

@@ tb/sv/free_fly_camera_update_tb.sv @@
`timescale 1ns / 1ps

module free_fly_camera_update_tb;
  import fcu_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HALF_TURN_Q7 = 23040;
  localparam int QUARTER_Q7 = 11520;
  localparam int PITCH_MAX = 11392;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  fcu_in_if in_ch();
  fcu_out_if out_ch();

  free_fly_camera_update u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  longint atan_tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                           57, 29, 14, 7, 4, 2, 1, 0};

  int up_v[3];
  int start_v[3];
  int yaw, pitch;
  int fwd[3], side[3], pos[3];

  fcu_item_t pending_q[$];
  fcu_res_t  pose_q[$];
  int errors = 0;
  int sent_cnt = 0;
  int taken_cnt = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int cycles = 0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic int clamp14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return int'(v);
  endfunction

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int mul14(int a, int b);
    return int'((longint'(a) * b + 8192) >>> 14);
  endfunction

  function automatic void sin_cos(input int ang, output int s, output int c);
    longint x, y, z, dx, dy;
    bit flip;
    int n;
    flip = 0;
    x = 652032874;
    y = 0;
    if (ang > QUARTER_Q7) begin
      ang -= HALF_TURN_Q7;
      flip = 1;
    end else if (ang < -QUARTER_Q7) begin
      ang += HALF_TURN_Q7;
      flip = 1;
    end
    z = longint'(ang) * 512;
    n = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    c = clamp14((x + 32768) >>> 16);
    s = clamp14((y + 32768) >>> 16);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void update_side();
    longint c[3];
    longint mx, q;
    longint unsigned len, m;
    c[0] = longint'(up_v[1]) * fwd[2] - longint'(up_v[2]) * fwd[1];
    c[1] = longint'(up_v[2]) * fwd[0] - longint'(up_v[0]) * fwd[2];
    c[2] = longint'(up_v[0]) * fwd[1] - longint'(up_v[1]) * fwd[0];
    while (1) begin
      mx = mag64(c[0]);
      if (mag64(c[1]) > mx) mx = mag64(c[1]);
      if (mag64(c[2]) > mx) mx = mag64(c[2]);
      if (mx >= (64'sd1 << 20)) begin
        for (int i = 0; i < 3; i++) c[i] = c[i] >>> 1;
      end else if (mx != 0 && mx < (64'sd1 << 19)) begin
        for (int i = 0; i < 3; i++) c[i] = c[i] * 2;
      end else begin
        break;
      end
    end
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) side[i] = 0;
      return;
    end
    len = root64(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
    for (int i = 0; i < 3; i++) begin
      m = mag64(c[i]) * 16384;
      q = longint'((m + len / 2) / len);
      side[i] = clamp14(c[i] < 0 ? -q : q);
    end
  endfunction

  function automatic void turn(int dx, int dy);
    int y, p, sp, cp, st, ct;
    y = yaw - 64 * dx;
    y = ((y + HALF_TURN_Q7) % (2 * HALF_TURN_Q7) + 2 * HALF_TURN_Q7) % (2 * HALF_TURN_Q7)
        - HALF_TURN_Q7;
    yaw = y;
    p = pitch - 64 * dy;
    if (p > PITCH_MAX) p = PITCH_MAX;
    if (p < -PITCH_MAX) p = -PITCH_MAX;
    pitch = p;
    sin_cos(pitch, sp, cp);
    sin_cos(yaw, st, ct);
    if (up_v[0] == 16384) begin
      fwd[0] = sp; fwd[1] = mul14(cp, ct); fwd[2] = mul14(cp, st);
    end else if (up_v[1] == 16384) begin
      fwd[0] = mul14(cp, st); fwd[1] = sp; fwd[2] = mul14(cp, ct);
    end else begin
      fwd[0] = mul14(cp, ct); fwd[1] = mul14(cp, st); fwd[2] = sp;
    end
    update_side();
  endfunction

  function automatic void step_pos(int v[3], int sgn);
    for (int i = 0; i < 3; i++) pos[i] = sat32(longint'(pos[i]) + longint'(sgn) * 2 * v[i]);
  endfunction

  function automatic fcu_res_t camera_pose(fcu_item_t it);
    fcu_res_t r;
    int t[3];
    case (it.cmd)
      OP_INIT: begin
        pos = start_v;
        yaw = int'(YAW_START);
        pitch = int'(PITCH_START);
        turn(0, 0);
      end
      OP_ORIENT: turn(int'(it.mouse_dx), int'(it.mouse_dy));
      OP_MOVE: begin
        case (it.move_dir)
          DIR_FWD:   step_pos(fwd, 1);
          DIR_BACK:  step_pos(fwd, -1);
          DIR_LEFT:  step_pos(side, 1);
          DIR_RIGHT: step_pos(side, -1);
          DIR_UP:    step_pos(up_v, 1);
          DIR_DOWN:  step_pos(up_v, -1);
          default: ;
        endcase
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) t[i] = sat32(longint'(pos[i]) + longint'(fwd[i]) * 4);
    r.pos_x = pos[0]; r.pos_y = pos[1]; r.pos_z = pos[2];
    r.target_x = t[0]; r.target_y = t[1]; r.target_z = t[2];
    r.fwd_x = fwd[0]; r.fwd_y = fwd[1]; r.fwd_z = fwd[2];
    r.side_x = side[0]; r.side_y = side[1]; r.side_z = side[2];
    return r;
  endfunction

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      errors++;
      $display("%0t mismatch %s: expected %0d actual %0d", $realtime, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    fcu_item_t it;
    fcu_res_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        it.cmd = in_ch.cmd;
        it.mouse_dx = in_ch.mouse_dx;
        it.mouse_dy = in_ch.mouse_dy;
        it.move_dir = in_ch.move_dir;
        pose_q.push_back(camera_pose(it));
        taken_cnt <= taken_cnt + 1;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (pose_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none actual pos_x %0d", $realtime,
                   out_ch.pos_x);
        end else begin
          e = pose_q.pop_front();
          check_field("pos_x", e.pos_x, out_ch.pos_x);
          check_field("pos_y", e.pos_y, out_ch.pos_y);
          check_field("pos_z", e.pos_z, out_ch.pos_z);
          check_field("target_x", e.target_x, out_ch.target_x);
          check_field("target_y", e.target_y, out_ch.target_y);
          check_field("target_z", e.target_z, out_ch.target_z);
          check_field("fwd_x", e.fwd_x, out_ch.fwd_x);
          check_field("fwd_y", e.fwd_y, out_ch.fwd_y);
          check_field("fwd_z", e.fwd_z, out_ch.fwd_z);
          check_field("side_x", e.side_x, out_ch.side_x);
          check_field("side_y", e.side_y, out_ch.side_y);
          check_field("side_z", e.side_z, out_ch.side_z);
        end
      end
    end
  end

  always @(negedge clk) begin
    fcu_item_t it;
    if (rst_n) begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
      if (!in_ch.valid || taken_cnt == sent_cnt) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
          it = pending_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.cmd <= it.cmd;
          in_ch.mouse_dx <= it.mouse_dx;
          in_ch.mouse_dy <= it.mouse_dy;
          in_ch.move_dir <= it.move_dir;
          sent_cnt <= sent_cnt + 1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic reg_write(fcu_reg_t r, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(r) << 2; pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (r)
      REG_UP_X:    up_v[0] = int'($signed(v[15:0]));
      REG_UP_Y:    up_v[1] = int'($signed(v[15:0]));
      REG_UP_Z:    up_v[2] = int'($signed(v[15:0]));
      REG_START_X: start_v[0] = int'(v);
      REG_START_Y: start_v[1] = int'(v);
      REG_START_Z: start_v[2] = int'(v);
      default: ;
    endcase
  endtask

  task automatic setup(int ux, int uy, int uz, logic [31:0] sx, logic [31:0] sy,
                       logic [31:0] sz);
    reg_write(REG_UP_X, 32'(ux));
    reg_write(REG_UP_Y, 32'(uy));
    reg_write(REG_UP_Z, 32'(uz));
    reg_write(REG_START_X, sx);
    reg_write(REG_START_Y, sy);
    reg_write(REG_START_Z, sz);
  endtask

  function automatic void add(fcu_op_t c, int dx, int dy, int dir);
    fcu_item_t it;
    it.cmd = c;
    it.mouse_dx = 11'(dx);
    it.mouse_dy = 11'(dy);
    it.move_dir = 3'(dir);
    pending_q.push_back(it);
  endfunction

  function automatic void add_random(int n);
    int k, dx, dy;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if ($urandom_range(0, 2) == 0) begin
        dx = $urandom_range(0, 2047) - 1024;
        dy = $urandom_range(0, 2047) - 1024;
      end else begin
        dx = $urandom_range(0, 40) - 20;
        dy = $urandom_range(0, 40) - 20;
      end
      if (k < 8) add(OP_INIT, dx, dy, $urandom_range(0, 7));
      else if (k < 48) add(OP_ORIENT, dx, dy, $urandom_range(0, 7));
      else if (k < 95)
        add(OP_MOVE, dx, dy, ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7)
                                                         : $urandom_range(0, 5));
      else add(OP_NOP, dx, dy, $urandom_range(0, 7));
    end
  endfunction

  task automatic drain();
    while (pending_q.size() != 0 || taken_cnt != sent_cnt || pose_q.size() != 0)
      @(posedge clk);
  endtask

  function automatic int rnd_up();
    return $urandom_range(0, 32768) - 16384;
  endfunction

  initial begin
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.cmd = OP_NOP; in_ch.mouse_dx = '0; in_ch.mouse_dy = '0;
    in_ch.move_dir = '0;
    out_ch.ready = 1'b0;
    up_v = '{0, 16384, 0};
    start_v = '{0, 0, 0};
    yaw = int'(YAW_START);
    pitch = int'(PITCH_START);
    fwd = '{0, 0, 0}; side = '{0, 0, 0}; pos = '{0, 0, 0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 22 : (ph < 4) ? 87 : 0;
      recv_idle = (ph < 2) ? 87 : (ph < 4) ? 22 : 0;
      case (ph)
        0: setup(0, 16384, 0, 32'h0, 32'h0, 32'h0);
        1: setup(16384, 0, 0, 32'h7fffffff, 32'h80000000, $urandom);
        2: setup(0, 0, 16384, 32'h80000000, 32'h7fffffff, 32'h0);
        3: setup(0, 0, 0, $urandom, $urandom, $urandom);
        4: setup(-16384, -16384, -16384, 32'h7fff0000, 32'h80010000, 32'hffffffff);
        default: setup(rnd_up(), rnd_up(), rnd_up(), $urandom, $urandom, $urandom);
      endcase
      if (ph == 0) begin
        add(OP_ORIENT, 0, 0, 0);
        add(OP_MOVE, 0, 0, DIR_FWD);
        add(OP_INIT, 0, 0, 0);
        add(OP_ORIENT, 1023, 0, 0);
        add(OP_ORIENT, -1024, -1024, 7);
        add(OP_ORIENT, 0, 1023, 0);
        add(OP_ORIENT, 1023, 1023, 0);
        add(OP_ORIENT, -1024, 0, 0);
        for (int d = 0; d < 8; d++) add(OP_MOVE, 0, 0, d);
        add(OP_NOP, 1023, -1024, 7);
        add(OP_INIT, -1024, 1023, 7);
        add(OP_MOVE, 0, 0, DIR_LEFT);
      end
      add(OP_INIT, 0, 0, 0);
      add_random(250);
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
